// ===== rtl/bci_pkg.sv =====
`timescale 1ns / 1ps
package bci_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam int TIME_W     = 32;
	localparam int VAL_W      = 16;
	localparam int QUO_W      = VAL_W;
	localparam int DVD_W      = TIME_W + VAL_W;

	localparam logic [1:0] OP_QUERY  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;

	localparam logic [1:0] CFG_ANCHOR_TIME  = 2'd0;
	localparam logic [1:0] CFG_ANCHOR_VALUE = 2'd1;
	localparam logic [1:0] CFG_HOLD_MODE    = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [TIME_W-1:0] time_req;
		logic [VAL_W-1:0]  value;
	} bci_in_t;

	typedef struct packed {
		logic [VAL_W-1:0] level;
		logic [1:0]       status;
	} bci_out_t;

	typedef struct packed {
		logic [TIME_W-1:0] pt_time;
		logic [VAL_W-1:0]  pt_value;
	} bci_entry_t;

endpackage

// ===== rtl/bci_div.sv =====
`timescale 1ns / 1ps
module bci_div import bci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [TIME_W-1:0] divisor,
	output logic              done,
	output logic [QUO_W-1:0]  quotient
);

	localparam int STEP_W = $clog2(QUO_W + 1);

	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] divisor_q;
	logic [QUO_W-1:0]  low_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [TIME_W+1:0] trial;
	logic              ge;

	// The caller guarantees the upper dividend bits are below the divisor, so the
	// quotient fits in QUO_W bits and the remainder never exceeds TIME_W bits.
	assign trial = {1'b0, rem_q, low_q[QUO_W-1]} - {2'b00, divisor_q};
	assign ge    = ~trial[TIME_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == STEP_W'(1));
			if (start) begin
				rem_q     <= dividend[DVD_W-1:QUO_W];
				low_q     <= dividend[QUO_W-1:0];
				divisor_q <= divisor;
				step_q    <= STEP_W'(QUO_W);
				busy_q    <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= ge ? trial[TIME_W-1:0] : {rem_q[TIME_W-2:0], low_q[QUO_W-1]};
				low_q  <= {low_q[QUO_W-2:0], ge};
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = low_q;

endmodule

// ===== rtl/breakpoint_curve_interpolator.sv =====
`timescale 1ns / 1ps
// Append, clear and unused codes go straight to S_FINISH. A query outside the curve's ends ends at the
// end check; else a binary search over the point memory runs (each probe waits on the registered read),
// then, unless hold mode is set, a 16x32 multiply and a 16-step serial divide.
// One item is in work at a time; the output register lets the next item enter early.
// Asynchronous active-low reset empties the table and clears the configuration registers.
module breakpoint_curve_interpolator import bci_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  bci_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output bci_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_QCHK,
		S_SRCH,
		S_SWAIT,
		S_RDJ,
		S_GOTN,
		S_GOTP,
		S_CALC,
		S_MUL,
		S_DIVS,
		S_DIVW,
		S_FINISH
	} state_t;

	state_t state_q;

	bci_entry_t mem [MAX_POINTS];
	bci_entry_t rd_data_q;
	logic [IDX_W-1:0] mem_raddr;
	logic             mem_we;

	logic [TIME_W-1:0] anchor_time_q;
	logic [VAL_W-1:0]  anchor_value_q;
	logic              hold_mode_q;

	logic [CNT_W-1:0]  count_q;
	logic [TIME_W-1:0] first_time_q, last_time_q;
	logic [VAL_W-1:0]  first_value_q, last_value_q;

	logic [TIME_W-1:0] tq_q, tn_q, tp_q, dt_q, span_q;
	logic [VAL_W-1:0]  vn_q, vp_q, absdiff_q;
	logic              neg_q;
	logic [DVD_W-1:0]  prod_q;
	logic [IDX_W-1:0]  lo_q, hi_q, mid_q;
	bci_out_t          result_q, out_q;
	logic              out_valid_q;

	logic              anchored;
	logic [TIME_W-1:0] t0, tl;
	logic [VAL_W-1:0]  v0, vl;
	logic [IDX_W:0]    mid_sum;
	logic [IDX_W-1:0]  mid;
	logic [CNT_W-1:0]  last_idx;
	logic              append_full, append_order;
	logic [1:0]        in_status;
	logic              out_load;
	logic              div_start, div_done;
	logic [QUO_W-1:0]  div_quo;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The anchor leads the curve when the table is empty or starts strictly after it.
	assign anchored = (count_q == '0) || (first_time_q > anchor_time_q);
	assign t0       = anchored ? anchor_time_q : first_time_q;
	assign v0       = anchored ? anchor_value_q : first_value_q;
	assign tl       = (count_q == '0) ? anchor_time_q : last_time_q;
	assign vl       = (count_q == '0) ? anchor_value_q : last_value_q;

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[IDX_W:1];
	assign last_idx = count_q - CNT_W'(1);

	assign append_full  = (count_q >= CNT_W'(MAX_POINTS));
	assign append_order = (count_q != '0) && (in_data.time_req < last_time_q);
	assign in_status    = (in_data.op != OP_APPEND) ? ST_OK :
	                      append_full ? ST_FULL : append_order ? ST_ORDER : ST_OK;
	assign mem_we       = in_valid && in_ready && (in_data.op == OP_APPEND) &&
	                      !append_full && !append_order;
	assign div_start    = (state_q == S_DIVS);
	assign out_load     = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		case (state_q)
			S_SRCH:  mem_raddr = mid;
			S_GOTN:  mem_raddr = lo_q - IDX_W'(1);
			default: mem_raddr = lo_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[IDX_W-1:0]] <= '{pt_time: in_data.time_req, pt_value: in_data.value};
		end
		rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_time_q  <= '0;
			anchor_value_q <= '0;
			hold_mode_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ANCHOR_TIME:  anchor_time_q  <= cfg_data;
				CFG_ANCHOR_VALUE: anchor_value_q <= cfg_data[VAL_W-1:0];
				CFG_HOLD_MODE:    hold_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bci_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (span_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						tq_q     <= in_data.time_req;
						result_q <= '{level: '0, status: in_status};
						state_q  <= (in_data.op == OP_QUERY) ? S_QCHK : S_FINISH;
						case (in_data.op)
							OP_APPEND: begin
								if (!append_full && !append_order) begin
									if (count_q == '0) begin
										first_time_q  <= in_data.time_req;
										first_value_q <= in_data.value;
									end
									last_time_q  <= in_data.time_req;
									last_value_q <= in_data.value;
									count_q      <= count_q + CNT_W'(1);
								end
							end
							OP_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				S_QCHK: begin
					lo_q <= '0;
					hi_q <= last_idx[IDX_W-1:0];
					if (tq_q <= t0) begin
						result_q.level <= v0;
						state_q        <= S_FINISH;
					end else if (tq_q >= tl) begin
						result_q.level <= vl;
						state_q        <= S_FINISH;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					// Find the first stored point at or after the query time.
					mid_q <= mid;
					if (lo_q == hi_q) begin
						state_q <= S_RDJ;
					end else begin
						state_q <= S_SWAIT;
					end
				end
				S_SWAIT: begin
					if (tq_q <= rd_data_q.pt_time) begin
						hi_q <= mid_q;
					end else begin
						lo_q <= mid_q + IDX_W'(1);
					end
					state_q <= S_SRCH;
				end
				S_RDJ: state_q <= S_GOTN;
				S_GOTN: begin
					tn_q <= rd_data_q.pt_time;
					vn_q <= rd_data_q.pt_value;
					if (lo_q == '0) begin
						// Only reachable when the anchor leads the curve.
						tp_q    <= anchor_time_q;
						vp_q    <= anchor_value_q;
						state_q <= S_CALC;
					end else begin
						state_q <= S_GOTP;
					end
				end
				S_GOTP: begin
					tp_q    <= rd_data_q.pt_time;
					vp_q    <= rd_data_q.pt_value;
					state_q <= S_CALC;
				end
				S_CALC: begin
					dt_q   <= tq_q - tp_q;
					span_q <= tn_q - tp_q;
					neg_q  <= (vn_q < vp_q);
					absdiff_q <= (vn_q < vp_q) ? (vp_q - vn_q) : (vn_q - vp_q);
					if (hold_mode_q) begin
						result_q.level <= vp_q;
						state_q        <= S_FINISH;
					end else if (tn_q <= tp_q) begin
						result_q.level <= vn_q;
						state_q        <= S_FINISH;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= {{TIME_W{1'b0}}, absdiff_q} * {{VAL_W{1'b0}}, dt_q};
					state_q <= S_DIVS;
				end
				S_DIVS: state_q <= S_DIVW;
				S_DIVW: begin
					// Dividing the magnitude truncates toward zero, as a signed quotient would.
					if (div_done) begin
						result_q.level <= neg_q ? (vp_q - div_quo) : (vp_q + div_quo);
						state_q        <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_load) begin
						out_q   <= result_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
